/* design/gpr_pkg.sv */
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared constants, types and arithmetic helpers of the 5x5 pyramid reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

    // frame limits
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;

    // field and register widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    // register reset values and their effective sizes
    localparam int unsigned CFG_WIDTH_RST  = 512;
    localparam int unsigned CFG_HEIGHT_RST = 512;
    localparam int unsigned W_EFF_RST =
        (CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RST;
    localparam int unsigned H_EFF_RST =
        (CFG_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RST;

    // position counters and effective sizes
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
    localparam int unsigned WSZ_W = COL_W + 1;
    localparam int unsigned HSZ_W = ROW_W + 1;

    // line store: four lines packed into one word per column
    localparam int unsigned LINES  = 4;
    localparam int unsigned LANE_W = $clog2(LINES);
    localparam int unsigned TAPS   = 5;

    // filter arithmetic
    localparam int unsigned VS_W       = 13;   // vertical sum, at most 20*255
    localparam int unsigned SUM_W      = 17;   // full sum plus rounding bias
    localparam int unsigned DIVISOR    = 400;
    localparam int unsigned ROUND_BIAS = DIVISOR / 2;
    localparam int unsigned RECIP_SH   = 26;
    localparam int unsigned RECIP_W    = 18;
    localparam int unsigned RECIP      = (1 << RECIP_SH) / DIVISOR;
    localparam int unsigned PROD_W     = SUM_W + RECIP_W;
    localparam int unsigned Q_W        = PROD_W - RECIP_SH;
    localparam int unsigned REM_W      = 10;   // remainder estimate below 800

    // result queue
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;
    localparam int unsigned PEND_W     = FIFO_AW + 1;

    // border handling of one axis, picks the folded tap set
    typedef enum logic [1:0] {
        EDGE_MID,   // window fully inside the frame
        EDGE_LOW,   // centered on coordinate zero
        EDGE_HIGH,  // centered one before the last coordinate
        EDGE_TINY   // two-pixel axis
    } t_edge;

    typedef struct packed {
        logic  trig;
        logic  fend;
        t_edge vmode;
        t_edge hmode;
    } t_tag;

    typedef struct packed {
        logic               valid;
        logic [PIX_W-1:0]   pixel;
        logic [LANE_W-1:0]  lane;
        t_tag               tag;
    } t_s1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             fend;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_res;

    typedef logic [LINES-1:0][PIX_W-1:0] t_word;
    typedef logic [TAPS-1:0][VS_W-1:0]   t_vec5;

    // register value limited to 2..hi
    function automatic logic [31:0] cfg_limit(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd2) begin
            x = 32'd2;
        end else if (x > hi) begin
            x = hi;
        end
        return x;
    endfunction

    // weighted sum of five samples with border taps folded in
    function automatic logic [SUM_W-1:0] wsum5(input t_edge mode, input t_vec5 v);
        logic [SUM_W-1:0] e0, e1, e2, e3, e4, s;
        e0 = SUM_W'(v[0]);
        e1 = SUM_W'(v[1]);
        e2 = SUM_W'(v[2]);
        e3 = SUM_W'(v[3]);
        e4 = SUM_W'(v[4]);
        case (mode)
            EDGE_MID: begin
                s = e0 + ((e1 << 2) + e1) + (e2 << 3) + ((e3 << 2) + e3) + e4;
            end
            EDGE_LOW: begin
                s = ((e2 << 4) - (e2 << 1)) + ((e3 << 2) + e3) + e4;
            end
            EDGE_HIGH: begin
                s = e1 + ((e2 << 2) + e2) + (e3 << 3) + ((e4 << 2) + (e4 << 1));
            end
            EDGE_TINY: begin
                s = ((e3 << 4) - (e3 << 1)) + ((e4 << 2) + (e4 << 1));
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/gpr_in_if.sv */
// ----------------------------------------------------------------------------
// gpr_in_if
// Input pixel stream: valid/ready handshake carrying one grey pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpr_in_if;
    import gpr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_pixel;

    modport source (output valid, output in_pixel, input ready);
    modport sink   (input valid, input in_pixel, output ready);
endinterface

`default_nettype wire

/* design/gpr_out_if.sv */
// ----------------------------------------------------------------------------
// gpr_out_if
// Output pixel stream: valid/ready handshake carrying one reduced pixel and
// the frame end flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpr_out_if;
    import gpr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             frame_end;

    modport source (output valid, output out_pixel, output frame_end, input ready);
    modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

/* design/gpr_line_store.sv */
// ----------------------------------------------------------------------------
// gpr_line_store
// Four-line pixel store, one 32-bit word per column. Each accepted pixel reads
// the whole column word and overwrites the lane of the oldest line.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_line_store (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [gpr_pkg::COL_W-1:0]   i_addr,
    input  logic [gpr_pkg::LANE_W-1:0]  i_lane,
    input  logic [gpr_pkg::PIX_W-1:0]   i_pixel,
    output gpr_pkg::t_word              o_word
);
    import gpr_pkg::*;

    t_word r_mem [MAX_WIDTH];
    t_word r_word;

    // read old column word, write new pixel into its lane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word                 <= r_mem[i_addr];
            r_mem[i_addr][i_lane]  <= i_pixel;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

/* design/gpr_filter.sv */
// ----------------------------------------------------------------------------
// gpr_filter
// 5x5 window, separable weighted sum with border folding, and rounding
// division by 400 (ties to even) through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  gpr_pkg::t_s1    i_s1,
    input  gpr_pkg::t_word  i_word,
    output gpr_pkg::t_res   o_res
);
    import gpr_pkg::*;

    logic [PIX_W-1:0]            r_win [TAPS][TAPS];   // [row][column]
    logic [TAPS-1:0][PIX_W-1:0]  col_new;

    logic                        r_v2, r_f2;
    t_edge                       r_vm2, r_hm2;
    t_vec5                       colv [TAPS];
    logic [SUM_W-1:0]            vs_full [TAPS];

    logic                        r_v3, r_f3;
    t_edge                       r_hm3;
    t_vec5                       r_vs;
    logic [SUM_W-1:0]            hsum;

    logic                        r_v4, r_f4;
    logic [SUM_W-1:0]            r_sum4;

    logic                        r_v5, r_f5;
    logic [SUM_W-1:0]            r_sum5;
    logic [PROD_W-1:0]           r_prod;

    logic [Q_W-1:0]              q_est;
    logic [SUM_W-1:0]            q_x400;
    logic [SUM_W-1:0]            rem_full;

    logic                        r_v6, r_f6;
    logic [Q_W-1:0]              r_q6;
    logic [REM_W-1:0]            r_rem6;

    logic [Q_W-1:0]              q_fix;
    logic [REM_W-1:0]            rem_fix;
    logic [Q_W-1:0]              q_fin;

    // new window column: stored lines rotated oldest first, live pixel last
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            col_new[k] = i_word[LANE_W'(i_s1.lane + LANE_W'(k))];
        end
        col_new[TAPS-1] = i_s1.pixel;
    end

    // window shift, one column per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < TAPS; k++) begin
                for (int j = 0; j < TAPS; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_s1.valid) begin
            for (int k = 0; k < TAPS; k++) begin
                for (int j = 0; j < TAPS - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
                r_win[k][TAPS-1] <= col_new[k];
            end
        end
    end

    // stage 2 control: only result-producing pixels go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_s1.valid && i_s1.tag.trig;
            if (i_s1.valid) begin
                r_f2  <= i_s1.tag.fend;
                r_vm2 <= i_s1.tag.vmode;
                r_hm2 <= i_s1.tag.hmode;
            end
        end
    end

    // vertical sums per window column
    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            for (int k = 0; k < TAPS; k++) begin
                colv[j][k] = VS_W'(r_win[k][j]);
            end
            vs_full[j] = wsum5(r_vm2, colv[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
            if (r_v2) begin
                r_f3  <= r_f2;
                r_hm3 <= r_hm2;
                for (int j = 0; j < TAPS; j++) begin
                    r_vs[j] <= vs_full[j][VS_W-1:0];
                end
            end
        end
    end

    // horizontal sum plus half the divisor
    assign hsum = wsum5(r_hm3, r_vs) + SUM_W'(ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
            if (r_v3) begin
                r_f4   <= r_f3;
                r_sum4 <= hsum;
            end
        end
    end

    // reciprocal multiply, quotient estimate may be one low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
            if (r_v4) begin
                r_f5   <= r_f4;
                r_sum5 <= r_sum4;
                r_prod <= {{RECIP_W{1'b0}}, r_sum4} * PROD_W'(RECIP);
            end
        end
    end

    // remainder of the estimate, 400 = 256 + 128 + 16
    always_comb begin
        q_est    = r_prod[PROD_W-1 -: Q_W];
        q_x400   = (SUM_W'(q_est) << 8) + (SUM_W'(q_est) << 7) + (SUM_W'(q_est) << 4);
        rem_full = r_sum5 - q_x400;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
            if (r_v5) begin
                r_f6   <= r_f5;
                r_q6   <= q_est;
                r_rem6 <= rem_full[REM_W-1:0];
            end
        end
    end

    // correct the estimate, then pull an exact tie back to the even value
    always_comb begin
        if (r_rem6 >= REM_W'(DIVISOR)) begin
            q_fix   = r_q6 + Q_W'(1);
            rem_fix = r_rem6 - REM_W'(DIVISOR);
        end else begin
            q_fix   = r_q6;
            rem_fix = r_rem6;
        end
        if (rem_fix == '0 && q_fix[0]) begin
            q_fin = q_fix - Q_W'(1);
        end else begin
            q_fin = q_fix;
        end
        o_res.valid      = r_v6;
        o_res.beat.pixel = q_fin[PIX_W-1:0];
        o_res.beat.fend  = r_f6;
    end

endmodule

`default_nettype wire

/* design/gpr_out_fifo.sv */
// ----------------------------------------------------------------------------
// gpr_out_fifo
// Small result queue between the filter pipeline and the output channel.
// Space is reserved at the input side, so a push never finds it full.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gpr_pkg::t_res   i_res,
    gpr_out_if.source       o_out,
    output logic            o_pop
);
    import gpr_pkg::*;

    t_beat               r_buf [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, r_rp;
    logic [PEND_W-1:0]   r_cnt, n_cnt;
    logic                pop;
    t_beat               head;

    assign pop   = o_out.valid && o_out.ready;
    assign o_pop = pop;
    assign n_cnt = r_cnt + PEND_W'(i_res.valid) - PEND_W'(pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_res.valid) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_buf[r_wp] <= i_res.beat;
        end
    end

    // head of queue drives the output beat
    assign head            = r_buf[r_rp];
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_pixel = head.pixel;
    assign o_out.frame_end = head.fend;

endmodule

`default_nettype wire

/* design/gaussian_pyramid_reduce_5x5.sv */
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_5x5
// One Gaussian pyramid level on a raster grey stream: 5x5 [1,5,8,5,1]/20
// kernel with replicated borders, decimated by two on both axes.
//
//   port        dir  handshake      beat contents
//   i_in        in   valid/ready    in_pixel
//   o_out       out  valid/ready    out_pixel, frame_end
//   i_cfg_*     in   write enable   i_cfg_idx selects width or height
//
// One input pixel per clock sustained while not stalled; the line store is
// read and written once per pixel at the column address, which sets that rate.
// A result passes window, sum, product, quotient registers, then the queue.
// Synchronous active-low reset; the line store needs no clearing pass.
// Input stalls only when the current pixel makes a result and 8 results are
// already in the pipeline or the output queue.
// A register write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_pyramid_reduce_5x5 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpr_pkg::CFG_W-1:0]      i_cfg_data,
    gpr_in_if.sink                         i_in,
    gpr_out_if.source                      o_out
);
    import gpr_pkg::*;

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [WSZ_W-1:0]   r_w_eff, n_w_eff;
    logic [HSZ_W-1:0]   r_h_eff, n_h_eff;
    logic [PEND_W-1:0]  r_pend, n_pend;
    t_s1                r_s1;

    logic [31:0]        lim_w, lim_h;
    logic               cfg_w_hit, cfg_h_hit, restart;
    logic               last_col, last_row;
    logic               col_end, row_end, col_even, row_even;
    logic               trig, ready, acc, pop;
    t_tag               tag;
    t_word              word;
    t_res               res;

    // position decode
    always_comb begin
        last_col = (WSZ_W'(r_col) == r_w_eff - WSZ_W'(1));
        last_row = (HSZ_W'(r_row) == r_h_eff - HSZ_W'(1));
        col_end  = last_col && !r_w_eff[0];
        row_end  = last_row && !r_h_eff[0];
        col_even = !r_col[0] && (r_col >= COL_W'(2));
        row_even = !r_row[0] && (r_row >= ROW_W'(2));
        trig     = (col_end || col_even) && (row_end || row_even);

        tag.trig = trig;
        tag.fend = last_col && last_row;
        if (col_end) begin
            tag.hmode = (r_col == COL_W'(1)) ? EDGE_TINY : EDGE_HIGH;
        end else begin
            tag.hmode = (r_col == COL_W'(2)) ? EDGE_LOW : EDGE_MID;
        end
        if (row_end) begin
            tag.vmode = (r_row == ROW_W'(1)) ? EDGE_TINY : EDGE_HIGH;
        end else begin
            tag.vmode = (r_row == ROW_W'(2)) ? EDGE_LOW : EDGE_MID;
        end
    end

    // input handshake, a result slot is reserved at acceptance
    assign ready      = !trig || (r_pend != PEND_W'(FIFO_DEPTH));
    assign i_in.ready = ready;
    assign acc        = i_in.valid && ready;

    // configuration decode
    always_comb begin
        cfg_w_hit = i_cfg_we && (i_cfg_idx == CFG_IDX_WIDTH);
        cfg_h_hit = i_cfg_we && (i_cfg_idx == CFG_IDX_HEIGHT);
        restart   = cfg_w_hit || cfg_h_hit;
        lim_w     = cfg_limit(i_cfg_data, MAX_WIDTH);
        lim_h     = cfg_limit(i_cfg_data, MAX_HEIGHT);
        n_w_eff   = cfg_w_hit ? lim_w[WSZ_W-1:0] : r_w_eff;
        n_h_eff   = cfg_h_hit ? lim_h[HSZ_W-1:0] : r_h_eff;
    end

    // raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (restart) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // results reserved but not yet delivered
    assign n_pend = r_pend + PEND_W'(acc && trig) - PEND_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_w_eff <= WSZ_W'(W_EFF_RST);
            r_h_eff <= HSZ_W'(H_EFF_RST);
            r_pend  <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_w_eff <= n_w_eff;
            r_h_eff <= n_h_eff;
            r_pend  <= n_pend;
        end
    end

    // pixel and its tag ride alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= acc;
            if (acc) begin
                r_s1.pixel <= i_in.in_pixel;
                r_s1.lane  <= r_row[LANE_W-1:0];
                r_s1.tag   <= tag;
            end
        end
    end

    gpr_line_store u_store (
        .i_clk   (i_clk),
        .i_en    (acc),
        .i_addr  (r_col),
        .i_lane  (r_row[LANE_W-1:0]),
        .i_pixel (i_in.in_pixel),
        .o_word  (word)
    );

    gpr_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart),
        .i_s1    (r_s1),
        .i_word  (word),
        .o_res   (res)
    );

    gpr_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_out   (o_out),
        .o_pop   (pop)
    );

endmodule

`default_nettype wire

/* design/gpr_checker.sv */
// ----------------------------------------------------------------------------
// gpr_checker
// Port-level checks of the pyramid reducer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [gpr_pkg::PIX_W-1:0]  i_out_pixel,
    input  logic                       i_out_frame_end
);
    import gpr_pkg::*;

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its contents
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_frame_end))
        else $error("output beat changed while stalled");

    // input only stalls on a full set of reserved results, some already queued
    a_stall_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with nothing queued at the output");

    // after reset nothing is queued and input is open
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind gaussian_pyramid_reduce_5x5 gpr_checker u_gpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_pixel     (o_out.out_pixel),
    .i_out_frame_end (o_out.frame_end)
);

`default_nettype wire
